[rtl/core/wv26_pkg.sv]
`timescale 1ns / 1ps

package wv26_pkg;

  // Highpass rounding and shift
  localparam int HP_ROUND = 4;
  localparam int HP_SHIFT = 3;

  // Headroom bits for the highpass sums
  localparam int GUARD_BITS = 6;

  // Most results one pair can release
  localparam int MAX_RES = 3;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_BITS   = 3;
  localparam int CNT_BITS   = 4;

  // Pair counts of a row that change the schedule
  localparam logic [1:0] PAIRS_FIRST_DUE = 2'd2;
  localparam logic [1:0] PAIRS_STEADY    = 2'd3;

  // Control of the pair that was just taken into the window
  typedef struct packed {
    logic       act;
    logic [1:0] seen;
    logic       last;
  } wv26_stage_t;

endpackage

[rtl/core/wavelet_2_6_forward_row.sv]
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// -------  ---------------------  -------------------------------------------------
// in       in_valid / in_stall    even_sample, odd_sample, row_end
// out      out_valid / out_stall  low_coeff, high_coeff, is_row_last, row_error
//
// Takes one sample pair per cycle while in_stall is low; each pair yields one result, a short row one.
// A result passes the window's stage register and then the result queue before it leaves;
// a pair's result waits for the next pair of its row, the row's first pair for two
// more, and the row's last pair releases its own.
// The 8-entry result queue sets in_stall: it rises when the queue cannot take three more.
// Reset (rst, synchronous) empties the queue and restarts the row; no clearing pass.
module wavelet_2_6_forward_row #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] even_sample,
  input  logic signed [SAMPLE_BITS-1:0] odd_sample,
  input  logic                          row_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS:0]   low_coeff,
  output logic signed [SAMPLE_BITS+1:0] high_coeff,
  output logic                          is_row_last,
  output logic                          row_error
);
  import wv26_pkg::*;

  localparam int LW = SAMPLE_BITS + 1;
  localparam int HW = SAMPLE_BITS + 2;
  localparam int EW = LW + HW + 2;

  wv26_stage_t                       stage;
  logic [2:0][SAMPLE_BITS-1:0]       ew;
  logic [2:0][SAMPLE_BITS-1:0]       ow;
  logic [MAX_RES-1:0][EW-1:0]        res;
  logic [1:0]                        push_cnt;
  logic [EW-1:0]                     head;
  logic [CNT_BITS-1:0]               count;
  logic                              accept;
  logic                              pop;

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  // Room for this cycle's results plus a full burst from the next transaction
  assign in_stall = ({1'b0, count} + (CNT_BITS + 1)'(push_cnt))
                    > (CNT_BITS + 1)'(FIFO_DEPTH - MAX_RES);

  wv26_window #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .even_sample (even_sample),
    .odd_sample  (odd_sample),
    .row_end     (row_end),
    .stage       (stage),
    .ew          (ew),
    .ow          (ow)
  );

  wv26_kernel #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_kernel (
    .stage    (stage),
    .ew       (ew),
    .ow       (ow),
    .res      (res),
    .push_cnt (push_cnt)
  );

  wv26_result_fifo #(
    .ENTRY_BITS(EW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wdata    (res),
    .push_cnt (push_cnt),
    .pop      (pop),
    .head     (head),
    .count    (count)
  );

  assign out_valid   = (count != '0);
  assign low_coeff   = head[EW-1 -: LW];
  assign high_coeff  = head[HW+1 -: HW];
  assign is_row_last = head[1];
  assign row_error   = head[0];

`ifndef SYNTHESIS
  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && row_error) |-> (low_coeff == '0 && high_coeff == '0 && is_row_last))
    else $error("row error result with nonzero coefficients");
`endif

endmodule

[rtl/core/wv26_window.sv]
`timescale 1ns / 1ps

module wv26_window #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [SAMPLE_BITS-1:0]          even_sample,
  input  logic [SAMPLE_BITS-1:0]          odd_sample,
  input  logic                            row_end,
  output wv26_pkg::wv26_stage_t           stage,
  output logic [2:0][SAMPLE_BITS-1:0]     ew,
  output logic [2:0][SAMPLE_BITS-1:0]     ow
);
  import wv26_pkg::*;

  logic [1:0] pairs_seen;
  logic [1:0] pairs_seen_next;

  always_comb begin
    if (row_end) begin
      pairs_seen_next = 2'd0;
    end else if (pairs_seen == PAIRS_STEADY) begin
      pairs_seen_next = PAIRS_STEADY;
    end else begin
      pairs_seen_next = pairs_seen + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_seen <= 2'd0;
      stage.act  <= 1'b0;
    end else begin
      stage.act <= accept;
      if (accept) begin
        pairs_seen <= pairs_seen_next;
        stage.seen <= pairs_seen;
        stage.last <= row_end;
      end
    end
  end

  // Advance the window, oldest pair in slot 0
  always_ff @(posedge clk) begin
    if (accept) begin
      ew[0]      <= ew[1];
      ow[0]      <= ow[1];
      ew[1]      <= ew[2];
      ow[1]      <= ow[2];
      ew[2]      <= even_sample;
      ow[2]      <= odd_sample;
    end
  end

`ifndef SYNTHESIS
  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && row_end) |=> (pairs_seen == 2'd0 && stage.act && stage.last))
    else $error("pair count not restarted after row end");
`endif

endmodule

[rtl/core/wv26_kernel.sv]
`timescale 1ns / 1ps

module wv26_kernel #(
  parameter int SAMPLE_BITS = 16
) (
  input  wv26_pkg::wv26_stage_t                               stage,
  input  logic [2:0][SAMPLE_BITS-1:0]                         ew,
  input  logic [2:0][SAMPLE_BITS-1:0]                         ow,
  output logic [wv26_pkg::MAX_RES-1:0][2*SAMPLE_BITS+4:0]     res,
  output logic [1:0]                                          push_cnt
);
  import wv26_pkg::*;

  localparam int W  = SAMPLE_BITS + GUARD_BITS;
  localparam int LW = SAMPLE_BITS + 1;
  localparam int HW = SAMPLE_BITS + 2;
  localparam int EW = LW + HW + 2;

  logic signed [W-1:0] e [3];
  logic signed [W-1:0] o [3];
  logic signed [W-1:0] lo [3];
  logic signed [W-1:0] sum_first;
  logic signed [W-1:0] sum_mid;
  logic signed [W-1:0] sum_last;
  logic signed [W-1:0] hi_first;
  logic signed [W-1:0] hi_mid;
  logic signed [W-1:0] hi_last;
  logic [EW-1:0]       ent_first;
  logic [EW-1:0]       ent_mid;
  logic [EW-1:0]       ent_last;
  logic [EW-1:0]       ent_short;
  logic                short_row;
  logic [1:0]          k;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e[i]  = W'(signed'(ew[i]));
      o[i]  = W'(signed'(ow[i]));
      lo[i] = e[i] + o[i];
    end
  end

  // 5*E0 - 11*O0 + 4*(E1+O1) - E2 - O2
  assign sum_first = (e[0] <<< 2) + e[0]
                   - ((o[0] <<< 3) + (o[0] <<< 1) + o[0])
                   + (lo[1] <<< 2) - lo[2] + W'(HP_ROUND);
  assign sum_mid   = lo[2] - lo[0] + W'(HP_ROUND);
  // 11*E2 - 5*O2 - 4*(E1+O1) + E0 + O0
  assign sum_last  = (e[2] <<< 3) + (e[2] <<< 1) + e[2]
                   - ((o[2] <<< 2) + o[2])
                   - (lo[1] <<< 2) + lo[0] + W'(HP_ROUND);

  assign hi_first = sum_first >>> HP_SHIFT;
  assign hi_mid   = (sum_mid >>> HP_SHIFT) + e[1] - o[1];
  assign hi_last  = sum_last >>> HP_SHIFT;

  assign ent_first = {lo[0][LW-1:0], hi_first[HW-1:0], 1'b0, 1'b0};
  assign ent_mid   = {lo[1][LW-1:0], hi_mid[HW-1:0], 1'b0, 1'b0};
  assign ent_last  = {lo[2][LW-1:0], hi_last[HW-1:0], 1'b1, 1'b0};
  assign ent_short = {{(LW + HW){1'b0}}, 1'b1, 1'b1};

  assign short_row = stage.last && (stage.seen < PAIRS_FIRST_DUE);

  // Compact the released results into the front slots
  always_comb begin
    res = '0;
    k   = 2'd0;
    if (stage.act) begin
      if (short_row) begin
        res[0] = ent_short;
        k      = 2'd1;
      end else begin
        if (stage.seen == PAIRS_FIRST_DUE) begin
          res[0] = ent_first;
          res[1] = ent_mid;
          k      = 2'd2;
        end else if (stage.seen == PAIRS_STEADY) begin
          res[0] = ent_mid;
          k      = 2'd1;
        end
        if (stage.last) begin
          res[k] = ent_last;
          k      = k + 2'd1;
        end
      end
    end
    push_cnt = k;
  end

endmodule

[rtl/core/wv26_result_fifo.sv]
`timescale 1ns / 1ps

module wv26_result_fifo #(
  parameter int ENTRY_BITS = 37
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic [wv26_pkg::MAX_RES-1:0][ENTRY_BITS-1:0]    wdata,
  input  logic [1:0]                                      push_cnt,
  input  logic                                            pop,
  output logic [ENTRY_BITS-1:0]                           head,
  output logic [wv26_pkg::CNT_BITS-1:0]                   count
);
  import wv26_pkg::*;

  logic [ENTRY_BITS-1:0] mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count_next;

  assign count_next = count + CNT_BITS'(push_cnt) - CNT_BITS'(pop);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_cnt);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_cnt) begin
        mem[wr_ptr + PTR_BITS'(i)] <= wdata[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count} + (CNT_BITS + 1)'(push_cnt)) <= (CNT_BITS + 1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty result queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push_cnt == 2'd0 && !pop) |=> $stable(count))
    else $error("queue count moved without a transaction");
`endif

endmodule
